>>> rtl/pcp_pkg.sv
`default_nettype none

package pcp_pkg;

  // Coordinate format: signed Q16.8, two's complement.
  localparam int COORD_WIDTH = 24;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;

  // Edge sign codes.
  typedef logic [1:0] sign_t;
  localparam sign_t SIGN_NONE = 2'd0;
  localparam sign_t SIGN_POS  = 2'd1;
  localparam sign_t SIGN_NEG  = 2'd2;

  // Point offset (o) and edge vector (e) of one edge.
  typedef struct packed {
    diff_t ox;
    diff_t oz;
    diff_t ex;
    diff_t ez;
  } edge_diff_t;

  // One classified vertex as it travels from the front to the back part.
  typedef struct packed {
    logic       open_v;    // an edge from the previous vertex ends here
    edge_diff_t open_e;
    logic       last;      // closing edge present and result due
    edge_diff_t close_e;
  } edge_item_t;

  typedef struct packed {
    sign_t edge_sign;
    logic  found_outside;
  } sign_state_t;

  // Sign code of an exact cross product.
  function automatic sign_t edge_code(cross_t c);
    sign_t code;
    if (c == '0) begin
      code = SIGN_NONE;
    end else if (c[CROSS_WIDTH-1]) begin
      code = SIGN_NEG;
    end else begin
      code = SIGN_POS;
    end
    return code;
  endfunction

  // Latch the first nonzero sign and flag any later opposite sign.
  function automatic sign_state_t sign_update(sign_state_t s, sign_t code);
    sign_state_t r;
    r = s;
    if (code != SIGN_NONE) begin
      if (s.edge_sign == SIGN_NONE) begin
        r.edge_sign = code;
      end else if (s.edge_sign != code) begin
        r.found_outside = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pcp_front.sv
`default_nettype none

module pcp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                q_full,
  input  wire pcp_pkg::coord_t     in_vertex_x,
  input  wire pcp_pkg::coord_t     in_vertex_z,
  input  wire pcp_pkg::coord_t     in_point_x,
  input  wire pcp_pkg::coord_t     in_point_z,
  input  wire logic                in_last_vertex,
  output logic                     in_stall,
  output logic                     push,
  output pcp_pkg::edge_item_t      push_item
);
  import pcp_pkg::*;

  coord_t first_vx_r, first_vz_r, prev_vx_r, prev_vz_r;
  logic   mid_polygon_r;
  coord_t first_x, first_z;

  // The queue being full is the only reason to hold off the source.
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // On the first vertex of a polygon the closing edge goes back to itself.
  assign first_x = mid_polygon_r ? first_vx_r : in_vertex_x;
  assign first_z = mid_polygon_r ? first_vz_r : in_vertex_z;

  // Edge differences are exact at one bit wider than the coordinates.
  always_comb begin
    push_item.open_v     = mid_polygon_r;
    push_item.open_e.ox  = diff_t'(in_point_x)  - diff_t'(prev_vx_r);
    push_item.open_e.oz  = diff_t'(in_point_z)  - diff_t'(prev_vz_r);
    push_item.open_e.ex  = diff_t'(in_vertex_x) - diff_t'(prev_vx_r);
    push_item.open_e.ez  = diff_t'(in_vertex_z) - diff_t'(prev_vz_r);
    push_item.last       = in_last_vertex;
    push_item.close_e.ox = diff_t'(in_point_x)  - diff_t'(in_vertex_x);
    push_item.close_e.oz = diff_t'(in_point_z)  - diff_t'(in_vertex_z);
    push_item.close_e.ex = diff_t'(first_x)     - diff_t'(in_vertex_x);
    push_item.close_e.ez = diff_t'(first_z)     - diff_t'(in_vertex_z);
  end

  // Polygon tracking state, updated on every transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_vx_r    <= '0;
      first_vz_r    <= '0;
      prev_vx_r     <= '0;
      prev_vz_r     <= '0;
      mid_polygon_r <= 1'b0;
    end else if (push) begin
      if (!mid_polygon_r) begin
        first_vx_r <= in_vertex_x;
        first_vz_r <= in_vertex_z;
      end
      prev_vx_r     <= in_vertex_x;
      prev_vz_r     <= in_vertex_z;
      mid_polygon_r <= !in_last_vertex;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcp_queue.sv
`default_nettype none

module pcp_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire pcp_pkg::edge_item_t push_item,
  input  wire logic                pop,
  output logic                     full,
  output logic                     not_empty,
  output pcp_pkg::edge_item_t      head_item
);
  import pcp_pkg::*;

  edge_item_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_WIDTH-1:0] count_r;
  logic                  do_push, do_pop;

  assign full      = (count_r == QCNT_WIDTH'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = mem_r[rd_ptr_r];

  // Storage needs no reset; only the pointers and count are cleared.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcp_back.sv
`default_nettype none

module pcp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_not_empty,
  input  wire pcp_pkg::edge_item_t q_item,
  input  wire logic                out_stall,
  output logic                     q_pop,
  output logic                     out_valid,
  output logic                     out_inside_res
);
  import pcp_pkg::*;

  // Multiply stage registers.
  logic  m_valid_r, m_open_v_r, m_last_r;
  prod_t m_open_pa_r, m_open_pb_r, m_close_pa_r, m_close_pb_r;
  prod_t open_pa, open_pb, close_pa, close_pb;

  // Sign stage state and output register.
  sign_state_t state_r, state_open, state_close;
  cross_t      open_cross, close_cross;
  sign_t       open_code, close_code;
  logic        out_valid_r, out_inside_r;
  logic        out_free, m_take, m_ready;

  // Flow control: only an item that carries a result needs the output slot.
  assign out_free = !out_valid_r || !out_stall;
  assign m_take   = m_valid_r && (!m_last_r || out_free);
  assign m_ready  = !m_valid_r || m_take;
  assign q_pop    = q_not_empty && m_ready;

  // Four independent products, two for each edge of the item.
  assign open_pa  = prod_t'(q_item.open_e.oz)  * prod_t'(q_item.open_e.ex);
  assign open_pb  = prod_t'(q_item.open_e.ox)  * prod_t'(q_item.open_e.ez);
  assign close_pa = prod_t'(q_item.close_e.oz) * prod_t'(q_item.close_e.ex);
  assign close_pb = prod_t'(q_item.close_e.ox) * prod_t'(q_item.close_e.ez);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_ready) begin
      m_valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_open_v_r   <= q_item.open_v;
      m_last_r     <= q_item.last;
      m_open_pa_r  <= open_pa;
      m_open_pb_r  <= open_pb;
      m_close_pa_r <= close_pa;
      m_close_pb_r <= close_pb;
    end
  end

  // Exact cross products and their sign codes.
  assign open_cross  = cross_t'(m_open_pa_r) - cross_t'(m_open_pb_r);
  assign close_cross = cross_t'(m_close_pa_r) - cross_t'(m_close_pb_r);
  assign open_code   = m_open_v_r ? edge_code(open_cross) : SIGN_NONE;
  assign close_code  = m_last_r ? edge_code(close_cross) : SIGN_NONE;

  // The open edge is applied before the closing edge.
  always_comb begin
    state_open  = sign_update(state_r, open_code);
    state_close = sign_update(state_open, close_code);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{edge_sign: SIGN_NONE, found_outside: 1'b0};
    end else if (m_take) begin
      if (m_last_r) begin
        state_r <= '{edge_sign: SIGN_NONE, found_outside: 1'b0};
      end else begin
        state_r <= state_close;
      end
    end
  end

  // Output register holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m_take && m_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_take && m_last_r) begin
      out_inside_r <= !state_close.found_outside;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

`default_nettype wire

>>> rtl/point_in_convex_polygon_top.sv
// Point-in-convex-polygon test on the x-z plane.
// Input channel: one polygon vertex per transfer (in_vertex_x, in_vertex_z)
// together with the query point (in_point_x, in_point_z), all signed Q16.8.
// in_last_vertex marks the final vertex; it closes the polygon with the edge
// back to the first vertex. A transfer is taken when in_valid is high and
// in_stall is low.
// Result channel: one out_inside_res per polygon, after the transfer of its last
// vertex; 1 means the point is inside or on the polygon. A result is taken
// when out_valid is high and out_stall is low.
// Throughput is one vertex per cycle while no result is held by out_stall, set by
// the four parallel 25x25 multipliers of the back part. A result reaches the
// output after the transfer of its last vertex through the queue, the multiply
// stage and the sign stage with its output register.
// Reset clears the polygon tracking, the four-entry queue and the sign state;
// no result is pending afterwards.
// While out_stall is high the pending result is held; vertices keep flowing
// until the queue fills, then in_stall rises.
`default_nettype none

module point_in_convex_polygon_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire pcp_pkg::coord_t in_vertex_x,
  input  wire pcp_pkg::coord_t in_vertex_z,
  input  wire pcp_pkg::coord_t in_point_x,
  input  wire pcp_pkg::coord_t in_point_z,
  input  wire logic            in_last_vertex,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_inside_res
);
  import pcp_pkg::*;

  edge_item_t push_item, head_item;
  logic       push, q_full, q_not_empty, q_pop;

  // Front: track vertices and form edge differences.
  pcp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .q_full         (q_full),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_z    (in_vertex_z),
    .in_point_x     (in_point_x),
    .in_point_z     (in_point_z),
    .in_last_vertex (in_last_vertex),
    .in_stall       (in_stall),
    .push           (push),
    .push_item      (push_item)
  );

  // Queue decoupling the two parts.
  pcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back: cross products, sign tracking and result.
  pcp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_item         (head_item),
    .out_stall      (out_stall),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_inside_res (out_inside_res)
  );

endmodule

`default_nettype wire
